[src/tscw_pkg.sv]
// Package for the text screen cursor writer.
// Holds field widths, command codes, register indexes, payload structs and the
// controller-to-datapath command and status structs. Depends on nothing.
package tscw_pkg;

    localparam int OFF_W    = 17;
    localparam int BYTE_W   = 8;
    localparam int LL_W     = 9;
    localparam int SCROLL_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MODE_PUT  = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_PUSH = 2'd2;
    localparam logic [1:0] MODE_POP  = 2'd3;

    localparam logic [BYTE_W-1:0] CHAR_PRINT_LO = 8'd32;
    localparam logic [BYTE_W-1:0] CHAR_PRINT_HI = 8'd127;
    localparam logic [BYTE_W-1:0] CHAR_BS       = 8'd8;
    localparam logic [BYTE_W-1:0] CHAR_LF       = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_CR       = 8'd13;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_CURSOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIOS_OUTPUT   = 2'd3;

    localparam logic [BYTE_W-1:0] RST_SCREEN_ROWS   = 8'd25;
    localparam logic [BYTE_W-1:0] RST_SCREEN_COLS   = 8'd80;
    localparam logic              RST_UPDATE_CURSOR = 1'b1;

    localparam logic [SCROLL_W-1:0] SCROLL_SAT = 9'd256;

    typedef struct packed {
        logic [1:0]        mode;
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] target_row;
        logic [BYTE_W-1:0] target_col;
    } t_in_item;

    typedef struct packed {
        logic                write_enable;
        logic [OFF_W-1:0]    write_offset;
        logic [BYTE_W-1:0]   write_row;
        logic [BYTE_W-1:0]   write_col;
        logic [BYTE_W-1:0]   write_char;
        logic [SCROLL_W-1:0] scroll_lines;
        logic [OFF_W-1:0]    scroll_attr_offset;
        logic                cursor_update;
        logic [BYTE_W-1:0]   cursor_row;
        logic [BYTE_W-1:0]   cursor_col;
        logic [BYTE_W-1:0]   top_row_out;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic start_div;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
    } t_dp_status;

endpackage

[src/tscw_div.sv]
// Restoring divider for the text screen cursor writer, one quotient bit a cycle.
// Divides a cursor offset by the line length. Depends on tscw_pkg.
module tscw_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tscw_pkg::OFF_W-1:0] i_dividend,
    input  logic [tscw_pkg::LL_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [tscw_pkg::OFF_W-1:0] o_quot,
    output logic [tscw_pkg::LL_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(tscw_pkg::OFF_W + 1);

    logic [CNT_W-1:0]           r_cnt;
    logic [tscw_pkg::OFF_W-1:0] r_num;
    logic [tscw_pkg::LL_W-1:0]  r_rem;
    logic [tscw_pkg::LL_W:0]    trial;
    logic                       take;

    assign trial = {r_rem, r_num[tscw_pkg::OFF_W-1]};
    assign take  = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(tscw_pkg::OFF_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[tscw_pkg::OFF_W-2:0], take};
            r_rem <= take ? tscw_pkg::LL_W'(trial - {1'b0, i_divisor})
                          : trial[tscw_pkg::LL_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

[src/tscw_datapath.sv]
// Datapath of the text screen cursor writer: configuration, cursor state,
// row multiplier, divider and the result register. Depends on tscw_pkg, tscw_div.
module tscw_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tscw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tscw_pkg::BYTE_W-1:0]    i_cfg_data,
    input  tscw_pkg::t_in_item             i_item,
    input  tscw_pkg::t_dp_cmd              i_cmd,
    output tscw_pkg::t_dp_status           o_status,
    output tscw_pkg::t_out_item            o_item
);

    logic [tscw_pkg::BYTE_W-1:0] r_rows;
    logic [tscw_pkg::BYTE_W-1:0] r_cols;
    logic                        r_upd;
    tscw_pkg::t_in_item          r_in;
    logic [tscw_pkg::OFF_W-1:0]  r_prod;
    logic [tscw_pkg::OFF_W-1:0]  r_off;
    logic [tscw_pkg::BYTE_W-1:0] r_top;
    logic [tscw_pkg::BYTE_W-1:0] r_srd;
    logic [tscw_pkg::BYTE_W-1:0] r_scol;
    tscw_pkg::t_out_item         r_out;

    logic [tscw_pkg::OFF_W-1:0]  n_off;
    logic [tscw_pkg::BYTE_W-1:0] n_top;
    logic [tscw_pkg::BYTE_W-1:0] n_srd;
    logic [tscw_pkg::BYTE_W-1:0] n_scol;
    tscw_pkg::t_out_item         n_out;

    logic [tscw_pkg::BYTE_W-1:0] rows_eff;
    logic [tscw_pkg::BYTE_W-1:0] cols_eff;
    logic [tscw_pkg::LL_W-1:0]   ll;
    logic [tscw_pkg::BYTE_W-1:0] mul_row;
    logic [tscw_pkg::OFF_W-1:0]  pop_off;
    logic [tscw_pkg::OFF_W-1:0]  dividend;
    logic                        div_busy;
    logic [tscw_pkg::OFF_W-1:0]  quot;
    logic [tscw_pkg::LL_W-1:0]   rem;
    logic                        set_ok;

    assign rows_eff = (r_rows == '0) ? 8'd1 : r_rows;
    assign cols_eff = (r_cols == '0) ? 8'd1 : r_cols;
    assign ll       = {cols_eff, 1'b0};
    assign pop_off  = r_prod + {8'b0, r_scol, 1'b0};
    assign dividend = (r_in.mode == tscw_pkg::MODE_POP) ? pop_off : r_off;
    assign set_ok   = (r_in.target_row < rows_eff) && (r_in.target_col < cols_eff);

    always_comb begin
        case (r_in.mode)
            tscw_pkg::MODE_SET: mul_row = r_in.target_row;
            tscw_pkg::MODE_POP: mul_row = r_top + r_srd;
            default:            mul_row = rows_eff - 8'd1;
        endcase
    end

    tscw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (dividend),
        .i_divisor  (ll),
        .o_busy     (div_busy),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    always_comb begin
        logic                          guard_en;
        logic [tscw_pkg::OFF_W:0]      off2;
        logic [tscw_pkg::OFF_W:0]      q2;
        logic [tscw_pkg::LL_W-1:0]     r2;
        logic [tscw_pkg::LL_W:0]       r_p2;
        logic                          wrap;
        logic [tscw_pkg::OFF_W:0]      n_scroll;
        logic [tscw_pkg::OFF_W-1:0]    q_fin;
        logic [tscw_pkg::LL_W-1:0]     r_fin;

        n_out    = '0;
        n_off    = r_off;
        n_top    = r_top;
        n_srd    = r_srd;
        n_scol   = r_scol;
        q_fin    = quot;
        r_fin    = rem;
        guard_en = 1'b0;
        off2     = '0;
        q2       = '0;
        r2       = '0;
        n_scroll = '0;
        r_p2     = {1'b0, rem} + 10'd2;
        wrap     = r_p2 >= {1'b0, ll};

        case (r_in.mode)
            tscw_pkg::MODE_PUT: begin
                n_out.cursor_update = r_upd;
                if (r_in.char_code inside {[tscw_pkg::CHAR_PRINT_LO:tscw_pkg::CHAR_PRINT_HI]}) begin
                    n_out.write_enable = 1'b1;
                    n_out.write_offset = r_off;
                    n_out.write_row    = quot[7:0];
                    n_out.write_col    = rem[8:1];
                    n_out.write_char   = r_in.char_code;
                    guard_en = 1'b1;
                    off2     = {1'b0, r_off} + 18'd2;
                    q2       = {1'b0, quot} + {17'b0, wrap};
                    r2       = wrap ? tscw_pkg::LL_W'(r_p2 - {1'b0, ll}) : r_p2[8:0];
                end else if (r_in.char_code == tscw_pkg::CHAR_BS) begin
                    if (r_off > 17'd2) begin
                        n_off = r_off - 17'd2;
                        if (rem >= 9'd2) begin
                            r_fin = rem - 9'd2;
                        end else begin
                            q_fin = quot - 17'd1;
                            r_fin = rem + ll - 9'd2;
                        end
                    end
                end else if (r_in.char_code == tscw_pkg::CHAR_CR) begin
                    n_off = r_off - {8'b0, rem};
                    r_fin = '0;
                end else if (r_in.char_code == tscw_pkg::CHAR_LF) begin
                    guard_en = 1'b1;
                    off2     = {1'b0, r_off} + {9'b0, ll};
                    q2       = {1'b0, quot} + 18'd1;
                    r2       = rem;
                end
            end
            tscw_pkg::MODE_SET: begin
                if (set_ok) begin
                    n_off = r_prod + {8'b0, r_in.target_col, 1'b0};
                    q_fin = {9'b0, r_in.target_row};
                    r_fin = {r_in.target_col, 1'b0};
                    n_top = r_in.target_row;
                end
            end
            tscw_pkg::MODE_PUSH: begin
                n_srd  = quot[7:0] - r_top;
                n_scol = rem[8:1];
            end
            default: begin
                n_off               = pop_off;
                n_out.cursor_update = r_upd;
            end
        endcase

        if (guard_en) begin
            if (q2 >= {10'b0, rows_eff}) begin
                n_scroll = q2 - {10'b0, rows_eff} + 18'd1;
                n_out.scroll_lines = (n_scroll > 18'd256) ? tscw_pkg::SCROLL_SAT
                                                          : n_scroll[8:0];
                n_out.scroll_attr_offset = tscw_pkg::OFF_W'(off2 - 18'd1);
                n_top = r_top - n_scroll[7:0];
                n_off = r_prod + {8'b0, r2};
                q_fin = {9'b0, rows_eff - 8'd1};
                r_fin = r2;
            end else begin
                n_off = off2[16:0];
                q_fin = q2[16:0];
                r_fin = r2;
            end
        end

        n_out.cursor_row  = q_fin[7:0];
        n_out.cursor_col  = r_fin[8:1];
        n_out.top_row_out = n_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= tscw_pkg::RST_SCREEN_ROWS;
            r_cols <= tscw_pkg::RST_SCREEN_COLS;
            r_upd  <= tscw_pkg::RST_UPDATE_CURSOR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tscw_pkg::CFG_SCREEN_ROWS:   r_rows <= i_cfg_data;
                tscw_pkg::CFG_SCREEN_COLS:   r_cols <= i_cfg_data;
                tscw_pkg::CFG_UPDATE_CURSOR: r_upd  <= i_cfg_data[0];
                // Both offset and row and column are always reported, so the
                // output mode register changes nothing and is not kept.
                tscw_pkg::CFG_BIOS_OUTPUT:   ;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= '0;
            r_top  <= '0;
            r_srd  <= '0;
            r_scol <= '0;
        end else if (i_cmd.commit) begin
            r_off  <= n_off;
            r_top  <= n_top;
            r_srd  <= n_srd;
            r_scol <= n_scol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_item;
        end
        r_prod <= tscw_pkg::OFF_W'({9'b0, mul_row} * {8'b0, ll});
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_status.div_busy = div_busy;
    assign o_item            = r_out;

endmodule

[src/tscw_ctrl.sv]
// Controller of the text screen cursor writer: sequences accept, multiply,
// divide and commit, and owns both channel handshakes. Depends on tscw_pkg.
module tscw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  tscw_pkg::t_dp_status i_status,
    output tscw_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_START;
            end
            S_START: begin
                o_cmd.start_div = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.commit | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

[src/text_screen_cursor_writer.sv]
// Top level of the text screen cursor writer.
// Joins the controller and the datapath. Depends on tscw_pkg, tscw_ctrl, tscw_datapath.
//
// Usage:
// Input items arrive on i_item with i_in_valid; a transfer happens at a rising
// edge where i_in_valid is high and o_in_stall is low. Each item yields exactly
// one result on o_item with o_out_valid; that transfer happens where o_out_valid
// is high and i_out_stall is low.
// The block takes a new item only after the previous one is committed to the
// output register; the 17-step restoring divider splits the cursor offset into
// row and column.
// A finished result waits in the output register while i_out_stall is high and
// the next item is already taken and worked on; it is committed only once the
// output register is free or being emptied in the same cycle.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data at any
// edge, and is meant to change only while no item is in flight.
// Reset (i_rst_n low at a rising edge) clears the cursor offset, the top row and
// the saved position, empties the output register and restores 25 rows,
// 80 columns and cursor updates on.
module text_screen_cursor_writer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tscw_pkg::t_in_item             i_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tscw_pkg::t_out_item            o_item,
    input  logic                           i_cfg_we,
    input  logic [tscw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tscw_pkg::BYTE_W-1:0]    i_cfg_data
);

    tscw_pkg::t_dp_cmd    dp_cmd;
    tscw_pkg::t_dp_status dp_status;

    tscw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    tscw_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_item     (o_item)
    );

endmodule
